// File: rtl/core/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared widths, register indexes and control types of the nearest codeword
// search block.
// ----------------------------------------------------------------------------
package ncs_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int ENTRY_W     = 10;
  localparam int ELEMENT_W   = 8;
  localparam int DIST_W      = 24;
  localparam int SQ_W        = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 11;
  localparam int ENT_CFG_W   = 11;
  localparam int DIM_CFG_W   = 9;

  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int DEF_MAX_DIM     = 256;

  localparam logic [ENT_CFG_W-1:0] ENT_RESET = 11'd1024;
  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 9'd192;

  localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIMS    = 8'd1;

  typedef struct packed {
    logic valid;
    logic last;
  } elem_ctl_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] total;
  } dist_res_t;

endpackage

// File: rtl/core/ncs_dist_unit.sv
// ----------------------------------------------------------------------------
// ncs_dist_unit
// Shared subtract, square and accumulate unit: one element pair per cycle,
// gives the squared distance of an entry on its last element.
// ----------------------------------------------------------------------------
module ncs_dist_unit
  import ncs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  elem_ctl_t           ctl,
  input  logic [SAMPLE_W-1:0] code,
  input  logic [SAMPLE_W-1:0] query,
  output dist_res_t           res
);

  logic signed [SAMPLE_W:0]     diff;
  logic signed [2*SAMPLE_W+1:0] prod;
  logic [SQ_W-1:0]              sq;
  elem_ctl_t                    sq_ctl;
  logic [DIST_W-1:0]            acc;
  logic [DIST_W-1:0]            sum;

  assign diff = $signed({1'b0, code}) - $signed({1'b0, query});
  assign prod = diff * diff;
  assign sum  = acc + DIST_W'(sq);

  always_ff @(posedge clk) begin
    sq <= prod[SQ_W-1:0];
    if (sq_ctl.valid && sq_ctl.last) begin
      res.total <= sum;
    end
    if (rst) begin
      sq_ctl   <= '0;
      acc      <= '0;
      res.done <= 1'b0;
    end else begin
      sq_ctl   <= ctl;
      res.done <= 1'b0;
      if (sq_ctl.valid) begin
        if (sq_ctl.last) begin
          acc      <= '0;
          res.done <= 1'b1;
        end else begin
          acc <= sum;
        end
      end
    end
  end

endmodule

// File: rtl/core/nearest_codeword_search.sv
// ----------------------------------------------------------------------------
// nearest_codeword_search
// Full-search vector quantiser over a codebook in block memory.
// ----------------------------------------------------------------------------
// Load and query words are accepted only while idle; a query word with last starts a search.
// Search: every element of every entry in use goes through the single
// subtract/square/accumulate unit and the one codebook read port; the input is
// ready again in the cycle in which the result word becomes valid, later only
// while an earlier result word still waits.
// Synchronous reset clears control, counters and the running best; the
// codebook and query stores keep no reset and need no clearing pass.
module nearest_codeword_search
  import ncs_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_DIM     = DEF_MAX_DIM
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operation,
  input  logic [ENTRY_W-1:0]     entry,
  input  logic [ELEMENT_W-1:0]   element,
  input  logic [SAMPLE_W-1:0]    sample,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ENTRY_W-1:0]     best_index,
  output logic [DIST_W-1:0]      best_distance,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int EW    = $clog2(MAX_ENTRIES);
  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_ENTRIES * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [SAMPLE_W-1:0] cb_mem [DEPTH];
  logic [SAMPLE_W-1:0] q_mem  [MAX_DIM];

  logic [ENT_CFG_W-1:0] entries_in_use;
  logic [DIM_CFG_W-1:0] dims_in_use;

  logic [1:0]          state;
  logic [EW-1:0]       ent;
  logic [DW-1:0]       elem;
  logic [AW-1:0]       base;
  logic [EW-1:0]       last_entry;
  logic [DW-1:0]       last_elem;
  logic [EW-1:0]       cmp_entry;
  logic [EW-1:0]       best_entry;
  logic [DIST_W-1:0]   best_dist;
  logic [EW-1:0]       out_index;
  logic [DIST_W-1:0]   out_dist;
  logic [SAMPLE_W-1:0] cb_q;
  logic [SAMPLE_W-1:0] q_q;
  elem_ctl_t           rd_ctl;
  dist_res_t           res;

  logic                in_acc;
  logic                start;
  logic                publish;
  logic                elem_end;
  logic                ent_end;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [12:0]         ent_c;
  logic [9:0]          dims_c;
  logic                take;
  logic [31:0]         wide_idx;

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign start     = in_acc && operation && last;
  assign publish   = (state == ST_HOLD) && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  assign elem_end = (elem == last_elem);
  assign ent_end  = (ent == last_entry);
  assign rd_addr  = base + AW'(elem);
  assign wr_addr  = AW'(32'(entry) * MAX_DIM + 32'(element));

  always_comb begin
    if (entries_in_use == '0) begin
      ent_c = 13'd1;
    end else if (32'(entries_in_use) > MAX_ENTRIES) begin
      ent_c = 13'(MAX_ENTRIES);
    end else begin
      ent_c = 13'(entries_in_use);
    end
    if (dims_in_use == '0) begin
      dims_c = 10'd1;
    end else if (32'(dims_in_use) > MAX_DIM) begin
      dims_c = 10'(MAX_DIM);
    end else begin
      dims_c = 10'(dims_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ENT_RESET;
      dims_in_use    <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENTRIES: entries_in_use <= cfg_data;
        REG_DIMS:    dims_in_use    <= cfg_data[DIM_CFG_W-1:0];
        default:     ;
      endcase
    end
  end

  // stores: write on load/query words, one read port each during a search
  always_ff @(posedge clk) begin
    if (in_acc && !operation && (32'(entry) < MAX_ENTRIES) && (32'(element) < MAX_DIM)) begin
      cb_mem[wr_addr] <= sample;
    end
    if (in_acc && operation && (32'(element) < MAX_DIM)) begin
      q_mem[element[DW-1:0]] <= sample;
    end
    cb_q <= cb_mem[rd_addr];
    q_q  <= q_mem[elem];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ent        <= '0;
      elem       <= '0;
      base       <= '0;
      last_entry <= '0;
      last_elem  <= '0;
      rd_ctl     <= '0;
    end else begin
      rd_ctl <= '0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state      <= ST_RUN;
            ent        <= '0;
            elem       <= '0;
            base       <= '0;
            last_entry <= EW'(ent_c - 13'd1);
            last_elem  <= DW'(dims_c - 10'd1);
          end
        end
        ST_RUN: begin
          rd_ctl.valid <= 1'b1;
          rd_ctl.last  <= elem_end;
          if (elem_end) begin
            elem <= '0;
            ent  <= ent + EW'(1);
            base <= base + AW'(MAX_DIM);
            if (ent_end) begin
              state <= ST_DRAIN;
            end
          end else begin
            elem <= elem + DW'(1);
          end
        end
        ST_DRAIN: begin
          if (res.done && (cmp_entry == last_entry)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (publish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ncs_dist_unit u_dist (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rd_ctl),
    .code  (cb_q),
    .query (q_q),
    .res   (res)
  );

  // first entry always taken, later ones only when strictly closer
  assign take = (cmp_entry == '0) || (res.total < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_entry  <= '0;
      best_entry <= '0;
      best_dist  <= '0;
      out_index  <= '0;
      out_dist   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (publish) begin
        out_valid <= 1'b1;
        out_index <= best_entry;
        out_dist  <= best_dist;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (res.done) begin
        if (take) begin
          best_entry <= cmp_entry;
          best_dist  <= res.total;
        end
        if (cmp_entry == last_entry) begin
          cmp_entry <= '0;
        end else begin
          cmp_entry <= cmp_entry + EW'(1);
        end
      end
    end
  end

  assign wide_idx      = 32'(out_index);
  assign best_index    = wide_idx[ENTRY_W-1:0];
  assign best_distance = out_dist;

endmodule
